/* rtl/assert_macros.svh */
// Assertion macros shared by the RTL of the HSV to RGB converter.
// Depends on nothing; included by the modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Checked property, disabled while reset is asserted.
`define HSV_ASSERT(lbl, clk, rstn, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
	else $error("HSV assertion failed");
// Checked property that is also checked while reset is asserted.
`define HSV_ASSERT_ALWAYS(lbl, clk, prop) \
	lbl: assert property (@(posedge clk) prop) \
	else $error("HSV assertion failed");
`else
`define HSV_ASSERT(lbl, clk, rstn, prop)
`define HSV_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

/* rtl/hsv_pkg.sv */
// Types and constants of the HSV to RGB converter.
// Depends on nothing; used by hsv_scale, hsv_to_rgb_converter, the checker and the testbench.
`default_nettype none
package hsv_pkg;

	localparam int CHAN_W = 13;
	localparam int K_W    = 10;

	typedef logic [CHAN_W-1:0] chan_t;
	typedef logic [K_W-1:0]    ramp_t;
	typedef logic [2:0]        sector_t;

	// Hue circle in 1/16 degree units, six sectors of 60 degrees.
	localparam chan_t HUE_FULL   = 13'd5760;
	localparam chan_t HUE_SECTOR = 13'd960;

	// Sector codes, named after the hue span they cover.
	localparam sector_t SEC_R_TO_Y = 3'd0;
	localparam sector_t SEC_Y_TO_G = 3'd1;
	localparam sector_t SEC_G_TO_C = 3'd2;
	localparam sector_t SEC_C_TO_B = 3'd3;
	localparam sector_t SEC_B_TO_M = 3'd4;
	localparam sector_t SEC_M_TO_R = 3'd5;

	// Division by 960 is a shift by 6 and a division by 15. The division by 15
	// is a multiply by ceil(2^21 / 15) and a shift by 21, exact for a 17 bit
	// dividend since the rounding error times the dividend stays below 2^21.
	localparam int         SECTOR_SHIFT = 6;
	localparam int         QUOT_W       = 17;
	localparam int         RECIP_W      = 18;
	localparam int         RECIP_SHIFT  = 21;
	localparam logic [RECIP_W-1:0] RECIP_MUL = 18'd139811;

endpackage
`default_nettype wire

/* rtl/hsv_scale.sv */
// Two stage scaler of the HSV to RGB converter: x = (c * k) / 960.
// Depends on hsv_pkg.
`default_nettype none
module hsv_scale
	import hsv_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  in_valid,
	input  wire chan_t c,
	input  wire ramp_t k,
	output logic       x_valid,
	output chan_t      x
);

	localparam int PROD_W = CHAN_W + K_W;
	localparam int DIV_W  = QUOT_W + RECIP_W;

	logic              valid_s3;
	logic              valid_s4;
	logic [PROD_W-1:0] p_s3;
	logic [DIV_W-1:0]  div_s4;
	logic [QUOT_W-1:0] q;

	// Dropping the low six bits divides by 64; the remaining factor is 15.
	assign q = p_s3[SECTOR_SHIFT +: QUOT_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			valid_s3 <= in_valid;
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		p_s3   <= PROD_W'(c) * PROD_W'(k);
		div_s4 <= DIV_W'(q) * DIV_W'(RECIP_MUL);
	end

	assign x_valid = valid_s4;
	assign x       = div_s4[RECIP_SHIFT +: CHAN_W];

endmodule
`default_nettype wire

/* rtl/hsv_to_rgb_converter.sv */
// Top level of the HSV to RGB converter: five stage pixel pipeline.
// Depends on hsv_pkg, hsv_scale and assert_macros.svh.
//
//   channel  direction  handshake         words
//   command  in         start, busy       hue, saturation, brightness_value
//   result   out        done (one cycle)  red, green, blue
//
// One word is accepted in every cycle; busy is always low. Each result
// appears with done in order, once its word has passed the pipeline stages:
// clamp and hue wrap, sector search and value times saturation, chroma times
// ramp, the divide by 960 multiply, and the channel mix into the output
// registers. Reset clears only the valid bits.
// The receiver cannot stall, so the pipeline never holds.
`default_nettype none
`include "assert_macros.svh"
module hsv_to_rgb_converter
	import hsv_pkg::*;
#(
	parameter int FRACTION_BITS = 12
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  start,
	output logic       busy,
	input  wire chan_t hue,
	input  wire chan_t saturation,
	input  wire chan_t brightness_value,
	output logic       done,
	output chan_t      red,
	output chan_t      green,
	output chan_t      blue
);

	// Unit value of the fixed point format. With thirteen to sixteen fraction
	// bits it lies above any 13 bit input, so the clamp never acts.
	localparam int   ONE_W_BITS = 17;
	localparam logic [ONE_W_BITS-1:0] ONE_W = ONE_W_BITS'(1 << FRACTION_BITS);
	localparam int   VS_W   = 2 * CHAN_W;
	localparam int   VSX_W  = VS_W + 3;

	// Stage 1: clamp saturation and value to one, wrap the hue once.
	logic  valid_s1;
	chan_t h_s1, s_s1, v_s1;
	chan_t s_clamp, v_clamp, h_wrap;

	always_comb begin
		s_clamp = (ONE_W_BITS'(saturation) > ONE_W) ? ONE_W[CHAN_W-1:0] : saturation;
		v_clamp = (ONE_W_BITS'(brightness_value) > ONE_W) ? ONE_W[CHAN_W-1:0]
			: brightness_value;
		h_wrap  = (hue >= HUE_FULL) ? hue - HUE_FULL : hue;
	end

	// Stage 2: find the sector and the ramp inside it, and form value times
	// saturation. Odd sectors ramp down, even sectors ramp up.
	logic            valid_s2;
	sector_t         sector_s2;
	ramp_t           k_s2;
	logic [VS_W-1:0] vs_s2;
	chan_t           v_s2;
	sector_t         sector_d;
	chan_t           base_d;
	ramp_t           rem_d;
	ramp_t           k_d;

	always_comb begin
		if (h_s1 < HUE_SECTOR) begin
			sector_d = SEC_R_TO_Y;
			base_d   = 13'd0;
		end else if (h_s1 < 13'd1920) begin
			sector_d = SEC_Y_TO_G;
			base_d   = 13'd960;
		end else if (h_s1 < 13'd2880) begin
			sector_d = SEC_G_TO_C;
			base_d   = 13'd1920;
		end else if (h_s1 < 13'd3840) begin
			sector_d = SEC_C_TO_B;
			base_d   = 13'd2880;
		end else if (h_s1 < 13'd4800) begin
			sector_d = SEC_B_TO_M;
			base_d   = 13'd3840;
		end else begin
			sector_d = SEC_M_TO_R;
			base_d   = 13'd4800;
		end
		rem_d = K_W'(h_s1 - base_d);
		k_d   = sector_d[0] ? K_W'(HUE_SECTOR) - rem_d : rem_d;
	end

	// Stage 3: chroma is the top bits of value times saturation. The scaler
	// registers chroma times ramp here and the reciprocal product next.
	logic             valid_x;
	chan_t            x_s4;
	logic [VSX_W-1:0] vs_wide;
	chan_t            c_d;
	chan_t            c_s3, m_s3, c_s4, m_s4;
	sector_t          sector_s3, sector_s4;

	assign vs_wide = VSX_W'(vs_s2);
	assign c_d     = vs_wide[FRACTION_BITS +: CHAN_W];

	hsv_scale u_scale (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (valid_s2),
		.c        (c_d),
		.k        (k_s2),
		.x_valid  (valid_x),
		.x        (x_s4)
	);

	// Stage 5: place chroma and the intermediate by sector, add the offset.
	logic  valid_s5;
	chan_t red_s5, green_s5, blue_s5;
	chan_t r_d, g_d, b_d;

	always_comb begin
		case (sector_s4)
			SEC_R_TO_Y: begin
				r_d = c_s4;  g_d = x_s4;  b_d = '0;
			end
			SEC_Y_TO_G: begin
				r_d = x_s4;  g_d = c_s4;  b_d = '0;
			end
			SEC_G_TO_C: begin
				r_d = '0;    g_d = c_s4;  b_d = x_s4;
			end
			SEC_C_TO_B: begin
				r_d = '0;    g_d = x_s4;  b_d = c_s4;
			end
			SEC_B_TO_M: begin
				r_d = x_s4;  g_d = '0;    b_d = c_s4;
			end
			default: begin
				r_d = c_s4;  g_d = '0;    b_d = x_s4;
			end
		endcase
	end

	// Only the valid bits take reset; the payload follows them blindly.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			valid_s1 <= start;
			valid_s2 <= valid_s1;
			valid_s5 <= valid_x;
		end
	end

	always_ff @(posedge clk) begin
		h_s1      <= h_wrap;
		s_s1      <= s_clamp;
		v_s1      <= v_clamp;
		sector_s2 <= sector_d;
		k_s2      <= k_d;
		vs_s2     <= VS_W'(v_s1) * VS_W'(s_s1);
		v_s2      <= v_s1;
		c_s3      <= c_d;
		m_s3      <= v_s2 - c_d;
		sector_s3 <= sector_s2;
		c_s4      <= c_s3;
		m_s4      <= m_s3;
		sector_s4 <= sector_s3;
		red_s5    <= r_d + m_s4;
		green_s5  <= g_d + m_s4;
		blue_s5   <= b_d + m_s4;
	end

	assign busy  = 1'b0;
	assign done  = valid_s5;
	assign red   = red_s5;
	assign green = green_s5;
	assign blue  = blue_s5;

	// Every accepted word yields a result, and no result appears without one;
	// the intermediate never exceeds chroma.
	`HSV_ASSERT(a_result_follows, clk, arst_n, start |-> ##5 done)
	`HSV_ASSERT(a_no_phantom, clk, arst_n, done |-> $past(start, 5))
	`HSV_ASSERT(a_x_le_c, clk, arst_n, valid_x |-> (x_s4 <= c_s4))

endmodule
`default_nettype wire

/* dv/hsv_to_rgb_checker.sv */
// Checker for the HSV to RGB converter: watches the command and result ports,
// predicts each color word and compares it with what the block returns.
// Depends on hsv_pkg for the channel type, the hue constants and the sector codes.
`timescale 1ns / 1ps
module hsv_to_rgb_checker
	import hsv_pkg::*;
#(
	parameter int FRACTION_BITS = 12
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  start,
	input  wire logic  busy,
	input  wire chan_t hue,
	input  wire chan_t saturation,
	input  wire chan_t brightness_value,
	input  wire logic  done,
	input  wire chan_t red,
	input  wire chan_t green,
	input  wire chan_t blue,
	output int         error_count,
	output int         words_in_flight
);

	typedef struct packed {
		chan_t red;
		chan_t green;
		chan_t blue;
	} rgb_word_t;

	localparam logic [31:0] UNIT_LEVEL = 32'd1 << FRACTION_BITS;

	rgb_word_t rgb_expected_q[$];

	// Saturation and value above one are held at one before any math.
	function automatic rgb_word_t predict_rgb(chan_t h_in, chan_t s_in, chan_t v_in);
		logic [31:0] h, s, v, rem, ramp, chroma, mid, floor_lvl, r, g, b;
		sector_t     sec;
		rgb_word_t   w;
		s = (s_in > UNIT_LEVEL) ? UNIT_LEVEL : 32'(s_in);
		v = (v_in > UNIT_LEVEL) ? UNIT_LEVEL : 32'(v_in);
		h = 32'(h_in);
		if (h >= HUE_FULL)
			h = h - HUE_FULL;
		sec  = sector_t'(h / HUE_SECTOR);
		rem  = h - 32'(sec) * HUE_SECTOR;
		ramp = sec[0] ? (HUE_SECTOR - rem) : rem;
		chroma    = (v * s) >> FRACTION_BITS;
		mid       = (chroma * ramp) / HUE_SECTOR;
		floor_lvl = v - chroma;
		case (sec)
			SEC_R_TO_Y: begin r = chroma; g = mid;    b = 0;      end
			SEC_Y_TO_G: begin r = mid;    g = chroma; b = 0;      end
			SEC_G_TO_C: begin r = 0;      g = chroma; b = mid;    end
			SEC_C_TO_B: begin r = 0;      g = mid;    b = chroma; end
			SEC_B_TO_M: begin r = mid;    g = 0;      b = chroma; end
			default: begin    r = chroma; g = 0;      b = mid;    end
		endcase
		w.red   = chan_t'(r + floor_lvl);
		w.green = chan_t'(g + floor_lvl);
		w.blue  = chan_t'(b + floor_lvl);
		return w;
	endfunction

	initial begin
		error_count = 0;
	end

	// Results are retired before new words are queued; with a pipelined block
	// a word taken at this edge can never be the one that is done at it.
	always @(posedge clk) begin
		rgb_word_t exp_w;
		if (arst_n) begin
			if (done) begin
				if (rgb_expected_q.size() == 0) begin
					$display("%0t: unexpected result red %0d green %0d blue %0d",
						$time, red, green, blue);
					error_count = error_count + 1;
				end else begin
					exp_w = rgb_expected_q.pop_front();
					if (red !== exp_w.red) begin
						$display("%0t: red expected %0d actual %0d", $time, exp_w.red, red);
						error_count = error_count + 1;
					end
					if (green !== exp_w.green) begin
						$display("%0t: green expected %0d actual %0d",
							$time, exp_w.green, green);
						error_count = error_count + 1;
					end
					if (blue !== exp_w.blue) begin
						$display("%0t: blue expected %0d actual %0d", $time, exp_w.blue, blue);
						error_count = error_count + 1;
					end
				end
			end
			if (start && !busy)
				rgb_expected_q = {rgb_expected_q,
					predict_rgb(hue, saturation, brightness_value)};
		end
		words_in_flight <= rgb_expected_q.size();
	end

endmodule

/* dv/hsv_to_rgb_converter_tb.sv */
// Top of the HSV to RGB converter testbench: clock, reset and command stimulus.
// Depends on hsv_pkg, the converter RTL and hsv_to_rgb_checker for the verdict.
`timescale 1ns / 1ps
module hsv_to_rgb_converter_tb;
	import hsv_pkg::*;

	localparam int FRACTION_BITS = 12;
	// Settle time after the last result, so that a stray strobe would still be seen.
	localparam int SETTLE_CYCLES = 10;
	// About 725 words go in at one per cycle, plus idle gaps and drains;
	// the limit leaves a wide margin on top of the run they take.
	localparam int CYCLE_LIMIT   = 100000;
	localparam int RANDOM_WORDS  = 700;
	localparam int IDLE_PERCENT  = 15;

	logic  clk;
	logic  arst_n;
	logic  start;
	logic  busy;
	chan_t hue;
	chan_t saturation;
	chan_t brightness_value;
	logic  done;
	chan_t red;
	chan_t green;
	chan_t blue;
	int    error_count;
	int    words_in_flight;
	int    cycle_count;

	hsv_to_rgb_converter #(
		.FRACTION_BITS(FRACTION_BITS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.hue(hue),
		.saturation(saturation),
		.brightness_value(brightness_value),
		.done(done),
		.red(red),
		.green(green),
		.blue(blue)
	);

	hsv_to_rgb_checker #(
		.FRACTION_BITS(FRACTION_BITS)
	) checker_inst (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.hue(hue),
		.saturation(saturation),
		.brightness_value(brightness_value),
		.done(done),
		.red(red),
		.green(green),
		.blue(blue),
		.error_count(error_count),
		.words_in_flight(words_in_flight)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Watchdog: a hung pipeline or a lost result ends the run here.
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count = cycle_count + 1;
		end
		$display("DONE: errors detected");
		$finish;
	end

	// Present one word and hold it until the block takes it. Sampling busy
	// right after the edge sees the value the block had at that edge.
	task automatic send_word(input chan_t h, input chan_t s, input chan_t v);
		start            <= 1'b1;
		hue              <= h;
		saturation       <= s;
		brightness_value <= v;
		@(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	// Random idle cycles between words. The lowered start lands in a later
	// time step than the one that raised it, so the two never collide.
	task automatic idle_gap(input bit allow_idle);
		while (allow_idle && ($urandom_range(0, 99) < IDLE_PERCENT)) begin
			start <= 1'b0;
			@(posedge clk);
		end
	endtask

	// Stop sending until every predicted result has come back.
	task automatic drain_results();
		start <= 1'b0;
		@(posedge clk);
		while (words_in_flight != 0)
			@(posedge clk);
	endtask

	// Saturation and value: mostly legal levels, some above one so that the
	// clamp is hit, and a share of the exact edges.
	function automatic chan_t pick_level();
		int sel;
		sel = $urandom_range(0, 99);
		if (sel < 4)
			return chan_t'(0);
		else if (sel < 10)
			return chan_t'(1 << FRACTION_BITS);
		else if (sel < 12)
			return chan_t'((1 << FRACTION_BITS) + 1);
		else if (sel < 85)
			return chan_t'($urandom_range(0, 1 << FRACTION_BITS));
		else
			return chan_t'($urandom_range(0, 8191));
	endfunction

	// Hue: the full 13 bit range, with a share placed right on a sector
	// boundary or one unit either side of it, wrapped ones included.
	function automatic chan_t pick_hue();
		int edge_idx;
		int offset;
		if ($urandom_range(0, 99) < 15) begin
			edge_idx = $urandom_range(0, 8);
			offset   = $urandom_range(0, 2);
			return chan_t'(edge_idx * HUE_SECTOR + offset + 8191) ;
		end
		return chan_t'($urandom_range(0, 8191));
	endfunction

	initial begin
		// Every input is known from time zero; reset is held low first.
		arst_n           = 1'b0;
		start            = 1'b0;
		hue              = '0;
		saturation       = '0;
		brightness_value = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed words: each sector and its boundaries, the wrap at 360
		// degrees, the all-ones hue, no saturation, full and over-range
		// saturation and value, and black.
		send_word(13'd0,    13'd4096, 13'd4096);
		send_word(13'd959,  13'd4096, 13'd4096);
		send_word(13'd960,  13'd4096, 13'd4096);
		send_word(13'd1440, 13'd4096, 13'd4096);
		send_word(13'd1919, 13'd4096, 13'd4096);
		send_word(13'd1920, 13'd4096, 13'd4096);
		send_word(13'd2880, 13'd4096, 13'd4096);
		idle_gap(1'b1);
		send_word(13'd3840, 13'd4096, 13'd4096);
		send_word(13'd4800, 13'd4096, 13'd4096);
		send_word(13'd5759, 13'd4096, 13'd4096);
		send_word(13'd5760, 13'd4096, 13'd4096);
		send_word(13'd6720, 13'd3000, 13'd2500);
		send_word(13'd8191, 13'd4096, 13'd4096);
		send_word(13'd8191, 13'd8191, 13'd8191);
		send_word(13'd3000, 13'd0,    13'd4096);
		send_word(13'd3000, 13'd0,    13'd0);
		send_word(13'd1000, 13'd4096, 13'd0);
		send_word(13'd500,  13'd4097, 13'd4096);
		send_word(13'd2500, 13'd4096, 13'd4097);
		send_word(13'd4000, 13'd8191, 13'd2048);
		send_word(13'd5000, 13'd2048, 13'd8191);
		send_word(13'd480,  13'd1,    13'd1);
		send_word(13'd1234, 13'd2731, 13'd3277);
		send_word(13'd0,    13'd0,    13'd0);

		// Let the directed words come back before the random part starts.
		drain_results();

		for (int i = 0; i < RANDOM_WORDS; i++) begin
			send_word(pick_hue(), pick_level(), pick_level());
			// A stretch of back to back words keeps every pipeline stage full.
			idle_gap(!(i >= 200 && i < 400));
			if (i == 450)
				drain_results();
		end
		start <= 1'b0;

		// Wait for the pipeline to empty, then a little longer for strays.
		while (words_in_flight != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (error_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
